// ===== hdl/wpbf_pkg.sv =====
// ----------------------------------------------------------------------------
// wpbf_pkg
// Types and constants shared by the windowed photon burst filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wpbf_pkg;

    // field widths
    localparam int CHAN_W   = 8;
    localparam int COARSE_W = 48;
    localparam int FINE_W   = 32;
    localparam int WIDTH_W  = 32;
    localparam int MINC_W   = 7;
    localparam int PAY_W    = CHAN_W + FINE_W;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ORIGIN = 2'd2;

    // request commands
    localparam logic CMD_PHOTON = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [CHAN_W-1:0]   channel;
        logic [COARSE_W-1:0] coarse_time;
        logic [FINE_W-1:0]   fine_time;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0]   out_channel;
        logic [COARSE_W-1:0] out_coarse_time;
        logic [FINE_W-1:0]   out_fine_time;
        logic                last;
        logic                overflowed;
    } t_out_item;

    // one buffered photon
    typedef struct packed {
        logic [COARSE_W-1:0] coarse;
        logic [PAY_W-1:0]    payload;
    } t_entry;

    // control that every cell of the buffer chain sees
    typedef struct packed {
        logic push;
        logic shift;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== hdl/wpbf_cell.sv =====
// ----------------------------------------------------------------------------
// wpbf_cell
// One slot of the photon buffer chain: loads a new photon when the fill
// count points at it, and takes its upper neighbor's photon on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module wpbf_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  wire                       i_clk,
    input  wpbf_pkg::t_cell_ctrl      i_ctrl,
    input  wire  [CNT_W-1:0]          i_count,
    input  wpbf_pkg::t_entry          i_new,
    input  wpbf_pkg::t_entry          i_next,
    output wpbf_pkg::t_entry          o_entry
);

    wpbf_pkg::t_entry r_entry;
    wpbf_pkg::t_entry n_entry;

    // pick load, shift or hold
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.shift) begin
            n_entry = i_next;
        end else if (i_ctrl.push && (i_count == CNT_W'(IDX))) begin
            n_entry = i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// ===== hdl/wpbf_rem.sv =====
// ----------------------------------------------------------------------------
// wpbf_rem
// Bit-serial remainder unit: one dividend bit per cycle, 48-bit dividend
// by 32-bit divisor, restoring form.
// ----------------------------------------------------------------------------
`default_nettype none

module wpbf_rem (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_start,
    input  wire  [wpbf_pkg::COARSE_W-1:0]   i_dividend,
    input  wire  [wpbf_pkg::WIDTH_W-1:0]    i_divisor,
    output logic                            o_done,
    output logic [wpbf_pkg::WIDTH_W-1:0]    o_rem
);

    localparam int DW    = wpbf_pkg::COARSE_W;
    localparam int WW    = wpbf_pkg::WIDTH_W;
    localparam int ITR_W = $clog2(DW);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [ITR_W-1:0]  r_iter, n_iter;
    logic [DW-1:0]     r_dvd, n_dvd;
    logic [WW-1:0]     r_dvs, n_dvs;
    logic [WW-1:0]     r_rem, n_rem;
    logic [WW:0]       w_trial;

    assign w_trial = {r_rem, r_dvd[DW-1]};

    // one restoring step per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_iter = r_iter;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_iter = '0;
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_dvs}) begin
                n_rem = WW'(w_trial - {1'b0, r_dvs});
            end else begin
                n_rem = w_trial[WW-1:0];
            end
            n_dvd  = {r_dvd[DW-2:0], 1'b0};
            n_iter = r_iter + 1'b1;
            if (r_iter == ITR_W'(DW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_iter <= n_iter;
        end
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== hdl/windowed_photon_burst_filter_unit.sv =====
// ----------------------------------------------------------------------------
// windowed_photon_burst_filter_unit
// Sorts time-ordered photons into fixed-width windows, buffers each window's
// photons in a chain of cells and emits a window's run when it holds enough.
//
//   channel   direction  handshake               payload
//   in        request    i_in_valid / o_in_ready   t_in_item
//   out       result     o_out_valid / i_out_ready t_out_item
//   cfg       write      i_cfg_valid / o_cfg_ready index + data
//
// A photon inside the window or before it passes through the evaluate state
// before the next ready. A flush passes through evaluate and close and then
// emits its photons, paced by the output register; a photon past the window
// takes the same path plus a setup state and the 48-step remainder unit for the
// realignment of the window start. Reset is synchronous; no clearing pass.
// Output stalls hold the emission chain; the input waits until idle.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_photon_burst_filter_unit #(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wpbf_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output wpbf_pkg::t_out_item                 o_out_data,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [wpbf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [wpbf_pkg::COARSE_W-1:0]       i_cfg_data
);

    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int CW     = wpbf_pkg::COARSE_W;
    localparam int WW     = wpbf_pkg::WIDTH_W;
    localparam int MW     = wpbf_pkg::MINC_W;
    localparam int FW     = wpbf_pkg::FINE_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_CLOSE = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_ADV   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;

    // configuration
    logic [WW-1:0]  r_width;
    logic [MW-1:0]  r_min;

    // control state
    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_wstart, n_wstart;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_lost, n_lost;
    logic              r_out_valid, n_out_valid;
    wpbf_pkg::t_in_item  r_item;
    wpbf_pkg::t_out_item r_out, n_out;

    logic [WW-1:0]     w_eff_width;
    logic [CW:0]       w_wend;
    logic              w_slot_free;
    logic              w_out_load;
    logic              w_rem_start;
    logic              w_rem_done;
    logic [WW-1:0]     w_rem;
    logic              w_enough;
    wpbf_pkg::t_cell_ctrl w_ctrl;
    wpbf_pkg::t_entry  w_new;
    wpbf_pkg::t_entry  w_entry [BUFFER_DEPTH];

    assign w_eff_width = (r_width == '0) ? WW'(1) : r_width;
    assign w_wend      = {1'b0, r_wstart} + (CW + 1)'(w_eff_width);
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_enough    = (r_count != '0) && (MW'(r_count) >= r_min);
    assign w_new       = '{coarse: r_item.coarse_time,
                           payload: {r_item.channel, r_item.fine_time}};

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // configuration writes; the origin only reloads the window start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'(1);
            r_min    <= MW'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                wpbf_pkg::REG_WINDOW_WIDTH:  r_width  <= i_cfg_data[WW-1:0];
                wpbf_pkg::REG_MIN_COUNT:     r_min    <= i_cfg_data[MW-1:0];
                default: ;
            endcase
        end
    end

    // window remainder unit
    wpbf_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (r_item.coarse_time - r_wstart),
        .i_divisor  (w_eff_width),
        .o_done     (w_rem_done),
        .o_rem      (w_rem)
    );

    // sequencer: classify, close, emit, realign, store
    always_comb begin
        n_state     = r_state;
        n_wstart    = r_wstart;
        n_count     = r_count;
        n_lost      = r_lost;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_ctrl      = '{push: 1'b0, shift: 1'b0};
        w_out_load  = 1'b0;
        w_rem_start = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_item.cmd == wpbf_pkg::CMD_FLUSH) begin
                    n_state = S_CLOSE;
                end else if (r_item.coarse_time < r_wstart) begin
                    n_state = S_IDLE;
                end else if ({1'b0, r_item.coarse_time} >= w_wend) begin
                    n_state = S_CLOSE;
                end else begin
                    n_state = S_IDLE;
                    if (r_count == CNT_W'(BUFFER_DEPTH)) begin
                        n_lost = 1'b1;
                    end else begin
                        w_ctrl.push = 1'b1;
                        n_count     = r_count + 1'b1;
                    end
                end
            end
            S_CLOSE: begin
                if (w_enough) begin
                    n_state = S_EMIT;
                end else begin
                    n_count = '0;
                    n_lost  = 1'b0;
                    n_state = (r_item.cmd == wpbf_pkg::CMD_FLUSH) ? S_IDLE : S_ADV;
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    w_out_load      = 1'b1;
                    w_ctrl.shift    = 1'b1;
                    n_out_valid     = 1'b1;
                    n_out.out_channel     = w_entry[0].payload[wpbf_pkg::PAY_W-1:FW];
                    n_out.out_coarse_time = w_entry[0].coarse;
                    n_out.out_fine_time   = w_entry[0].payload[FW-1:0];
                    n_out.last            = (r_count == CNT_W'(1));
                    n_out.overflowed      = r_lost;
                    n_count = r_count - 1'b1;
                    if (r_count == CNT_W'(1)) begin
                        n_lost  = 1'b0;
                        n_state = (r_item.cmd == wpbf_pkg::CMD_FLUSH) ? S_IDLE : S_ADV;
                    end
                end
            end
            S_ADV: begin
                w_rem_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_rem_done) begin
                    // buffer is empty here, so the photon lands in the first cell
                    n_wstart    = r_item.coarse_time - CW'(w_rem);
                    w_ctrl.push = 1'b1;
                    n_count     = CNT_W'(1);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // origin write reloads the window start
        if (i_cfg_valid && (i_cfg_index == wpbf_pkg::REG_WINDOW_ORIGIN)) begin
            n_wstart = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wstart    <= '0;
            r_count     <= '0;
            r_lost      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wstart    <= n_wstart;
            r_count     <= n_count;
            r_lost      <= n_lost;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in_data;
        end
    end

    // buffer chain, cell 0 is the oldest photon
    for (genvar g = 0; g < BUFFER_DEPTH; g++) begin : g_cell
        wpbf_pkg::t_entry w_next;
        if (g == BUFFER_DEPTH - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_body
            assign w_next = w_entry[g+1];
        end
        wpbf_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_count (r_count),
            .i_new   (w_new),
            .i_next  (w_next),
            .o_entry (w_entry[g])
        );
    end

    // fill count never passes the chain length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(BUFFER_DEPTH))
        else $error("buffer count beyond depth");

    // a result is only loaded while photons are held
    a_load_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (r_count != '0))
        else $error("emit from empty buffer");

    // last result of a run leaves the buffer empty and the loss flag clear
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && (r_count == CNT_W'(1))) |=> ((r_count == '0) && !r_lost))
        else $error("run end left state behind");

    // remainder completes only while the sequencer waits for it
    a_rem_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rem_done |-> (r_state == S_DIV))
        else $error("unexpected remainder completion");

endmodule

`default_nettype wire
